FILE: rtl/swld_pkg.sv
package swld_pkg;

   // Reset values of the sync word bytes
   localparam logic [7:0] SyncFirstReset  = 8'hDA;
   localparam logic [7:0] SyncSecondReset = 8'hBA;
   localparam logic [7:0] SyncThirdReset  = 8'hD0;
   localparam logic [7:0] SyncFourthReset = 8'h00;

   // Register indexes on the csr port
   localparam int unsigned CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CsrSyncFirst  = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSyncSecond = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSyncThird  = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSyncFourth = 8'd3;

   // Four expected sync bytes, first byte at index 0
   typedef logic [3:0][7:0] sync_pattern_type;

   // Parser phase
   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_SYNC2 = 3'd2,
      PH_SYNC3 = 3'd3,
      PH_LEN   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   // One result item
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
      logic [7:0] index;
      logic [7:0] count;
   } result_type;

endpackage

FILE: rtl/swld_parse.sv
module swld_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [7:0]                rx_byte,
   input  swld_pkg::sync_pattern_type sync_pattern,
   output logic                      emit,
   output swld_pkg::result_type      result
);

   swld_pkg::phase_type phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic       more_data;

   // Payload byte still to be delivered while count + 1 < length
   assign more_data = ({1'b0, count_ff} + 9'd1) < {1'b0, length_ff};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         swld_pkg::PH_HUNT: begin
            phase_in = (rx_byte == sync_pattern[0]) ? swld_pkg::PH_SYNC1 : swld_pkg::PH_HUNT;
         end
         swld_pkg::PH_SYNC1: begin
            phase_in = (rx_byte == sync_pattern[1]) ? swld_pkg::PH_SYNC2 : swld_pkg::PH_HUNT;
         end
         swld_pkg::PH_SYNC2: begin
            phase_in = (rx_byte == sync_pattern[2]) ? swld_pkg::PH_SYNC3 : swld_pkg::PH_HUNT;
         end
         swld_pkg::PH_SYNC3: begin
            phase_in = (rx_byte == sync_pattern[3]) ? swld_pkg::PH_LEN : swld_pkg::PH_HUNT;
         end
         swld_pkg::PH_LEN: begin
            phase_in = swld_pkg::PH_DATA;
         end
         swld_pkg::PH_DATA: begin
            phase_in = more_data ? swld_pkg::PH_DATA : swld_pkg::PH_HUNT;
         end
         default: begin
            phase_in = swld_pkg::PH_HUNT;
         end
      endcase
   end

   // Result and counters
   always_comb begin
      emit      = 1'b0;
      result    = '0;
      length_in = length_ff;
      count_in  = count_ff;
      case (phase_ff)
         swld_pkg::PH_LEN: begin
            length_in = rx_byte;
         end
         swld_pkg::PH_DATA: begin
            emit = 1'b1;
            if (more_data) begin
               result.data  = rx_byte;
               result.index = count_ff;
               count_in     = count_ff + 8'd1;
            end else begin
               result.is_end = 1'b1;
               result.count  = count_ff;
               count_in      = '0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= swld_pkg::PH_HUNT;
         length_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/swld_out.sv
module swld_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  swld_pkg::result_type result_in,
   input  logic                 rsp_stall,
   output logic                 out_free,
   output logic                 rsp_valid,
   output swld_pkg::result_type rsp_result
);

   logic                 vld_ff, vld_in;
   swld_pkg::result_type res_ff;

   // Register can take a new result when empty or its content leaves now
   assign out_free = !vld_ff || !rsp_stall;
   assign vld_in   = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result_in;
      end
   end

   assign rsp_valid  = vld_ff;
   assign rsp_result = res_ff;

endmodule

FILE: rtl/sync_word_length_deframer.sv
// Length-prefixed frame parser. One byte is taken per transfer on req_ and
// up to one byte per clock is sustained. The parser hunts for the four-byte
// sync word in csr registers 0..3, reads the next byte as a length L, then
// delivers payload bytes 0..L-2 on rsp_ with their index; byte L-1 is dropped
// and a frame-end result (rsp_is_end high) carries the delivered count.
// L of 0 or 1 gives an empty frame. The input register feeds the parse logic,
// which feeds the result register. The rate drops below one byte per clock
// only while rsp_stall holds the result register full and the next byte would
// produce a result. Csr writes are always accepted and take effect from the
// next byte; write only while idle.
module sync_word_length_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_is_end,
   output logic [7:0]                         rsp_data,
   output logic [7:0]                         rsp_index,
   output logic [7:0]                         rsp_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swld_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]                         csr_data
);

   swld_pkg::sync_pattern_type sync_ff, sync_in;
   swld_pkg::result_type       result, rsp_result;
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       emit, out_free, advance;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      sync_in = sync_ff;
      if (csr_valid) begin
         case (csr_index)
            swld_pkg::CsrSyncFirst:  sync_in[0] = csr_data;
            swld_pkg::CsrSyncSecond: sync_in[1] = csr_data;
            swld_pkg::CsrSyncThird:  sync_in[2] = csr_data;
            swld_pkg::CsrSyncFourth: sync_in[3] = csr_data;
            default:                 sync_in = sync_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= {swld_pkg::SyncFourthReset, swld_pkg::SyncThirdReset,
                     swld_pkg::SyncSecondReset, swld_pkg::SyncFirstReset};
      end else begin
         sync_ff <= sync_in;
      end
   end

   // Input register; the byte moves on unless its result finds the output full
   assign advance   = in_vld_ff && (!emit || out_free);
   assign req_stall = in_vld_ff && !advance;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   swld_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .rx_byte      (in_byte_ff),
      .sync_pattern (sync_ff),
      .emit         (emit),
      .result       (result)
   );

   swld_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emit),
      .result_in  (result),
      .rsp_stall  (rsp_stall),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_is_end = rsp_result.is_end;
   assign rsp_data   = rsp_result.data;
   assign rsp_index  = rsp_result.index;
   assign rsp_count  = rsp_result.count;

endmodule

FILE: rtl/swld_checker.sv
module swld_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_end,
   input logic [7:0] rsp_data,
   input logic [7:0] rsp_index,
   input logic [7:0] rsp_count
);

   logic       rsp_xfer;
   logic [7:0] seen_ff, seen_in;

   // Data transfers seen since the last frame end
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign seen_in  = (rsp_xfer && rsp_is_end) ? 8'd0 :
                     (rsp_xfer ? seen_ff + 8'd1 : seen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_end) && $stable(rsp_data)
         && $stable(rsp_index) && $stable(rsp_count))
      else $error("stalled result changed");

   // Data bytes are numbered in order within a frame
   a_index_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_index == seen_ff)
      else $error("payload index out of sequence");

   // Frame end reports the number of data bytes delivered
   a_end_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_count == seen_ff && rsp_data == 8'd0)
      else $error("frame end count mismatch");

endmodule

bind sync_word_length_deframer swld_checker u_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   // How the expected result of one driven byte is obtained
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_GIVEN
   } check_type;

   typedef struct packed {
      logic [7:0]           rx;
      check_type            kind;
      swld_pkg::result_type want;
   } stim_row_type;

   typedef logic [swld_pkg::CsrIndexWidth-1:0] csr_index_type;

   localparam int DIRECTED_ROWS  = 27;
   localparam int SETTINGS_COUNT = 6;
   localparam int ITEMS_PER_SET  = 110;
   localparam int MAX_WAIT       = 10;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_LIMIT     = 2000;
   localparam swld_pkg::result_type NO_RESULT = '0;

   // Directed bytes, reset sync word DA BA D0 00
   stim_row_type directed [DIRECTED_ROWS] = '{
      // plain frame of length 3: two data bytes at the extremes, then end
      '{8'hDA, CHECK_NONE,  NO_RESULT},
      '{8'hBA, CHECK_NONE,  NO_RESULT},
      '{8'hD0, CHECK_NONE,  NO_RESULT},
      '{8'h00, CHECK_NONE,  NO_RESULT},
      '{8'h03, CHECK_NONE,  NO_RESULT},
      '{8'h00, CHECK_GIVEN, '{1'b0, 8'h00, 8'h00, 8'h00}},
      '{8'hFF, CHECK_GIVEN, '{1'b0, 8'hFF, 8'h01, 8'h00}},
      '{8'h55, CHECK_GIVEN, '{1'b1, 8'h00, 8'h00, 8'h02}},
      // second byte repeats the first sync value: must not restart sync
      '{8'hDA, CHECK_MODEL, NO_RESULT},
      '{8'hDA, CHECK_MODEL, NO_RESULT},
      '{8'hBA, CHECK_MODEL, NO_RESULT},
      '{8'hD0, CHECK_MODEL, NO_RESULT},
      '{8'h00, CHECK_MODEL, NO_RESULT},
      '{8'h01, CHECK_MODEL, NO_RESULT},
      '{8'h33, CHECK_MODEL, NO_RESULT},
      // length zero closes an empty frame
      '{8'hDA, CHECK_NONE,  NO_RESULT},
      '{8'hBA, CHECK_NONE,  NO_RESULT},
      '{8'hD0, CHECK_NONE,  NO_RESULT},
      '{8'h00, CHECK_NONE,  NO_RESULT},
      '{8'h00, CHECK_NONE,  NO_RESULT},
      '{8'h77, CHECK_GIVEN, '{1'b1, 8'h00, 8'h00, 8'h00}},
      // length one closes an empty frame as well
      '{8'hDA, CHECK_NONE,  NO_RESULT},
      '{8'hBA, CHECK_NONE,  NO_RESULT},
      '{8'hD0, CHECK_NONE,  NO_RESULT},
      '{8'h00, CHECK_NONE,  NO_RESULT},
      '{8'h01, CHECK_NONE,  NO_RESULT},
      '{8'h12, CHECK_GIVEN, '{1'b1, 8'h00, 8'h00, 8'h00}}
   };

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   logic [7:0]    req_rx_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   logic          rsp_is_end;
   logic [7:0]    rsp_data;
   logic [7:0]    rsp_index;
   logic [7:0]    rsp_count;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index   = '0;
   logic [7:0]    csr_data    = 8'h00;

   // Check mode travels with the byte so the monitor sees it on transfer
   check_type            drv_kind = CHECK_MODEL;
   swld_pkg::result_type drv_want = NO_RESULT;

   // Parser shadow state
   swld_pkg::phase_type        prd_phase;
   logic [7:0]                 prd_len;
   logic [7:0]                 prd_cnt;
   swld_pkg::sync_pattern_type prd_sync;

   swld_pkg::result_type       pending_results [$];
   swld_pkg::sync_pattern_type drv_sync;
   int            sent_bytes   = 0;
   int            results_seen = 0;
   int            frame_ends   = 0;
   int            mismatches   = 0;
   int            quiet_cycles = 0;
   int            stall_left   = 0;
   int            stall_mark   = 0;
   bit            req_burst    = 1'b0;
   bit            rsp_burst    = 1'b0;

   sync_word_length_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_is_end  (rsp_is_end),
      .rsp_data    (rsp_data),
      .rsp_index   (rsp_index),
      .rsp_count   (rsp_count),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One parser step: advances the shadow state, returns 1 when a result is due
   function automatic logic deframe_byte(input logic [7:0] b,
                                         output swld_pkg::result_type r);
      r = '0;
      deframe_byte = 1'b0;
      case (prd_phase)
         swld_pkg::PH_HUNT:
            prd_phase = (b == prd_sync[0]) ? swld_pkg::PH_SYNC1 : swld_pkg::PH_HUNT;
         swld_pkg::PH_SYNC1:
            prd_phase = (b == prd_sync[1]) ? swld_pkg::PH_SYNC2 : swld_pkg::PH_HUNT;
         swld_pkg::PH_SYNC2:
            prd_phase = (b == prd_sync[2]) ? swld_pkg::PH_SYNC3 : swld_pkg::PH_HUNT;
         swld_pkg::PH_SYNC3:
            prd_phase = (b == prd_sync[3]) ? swld_pkg::PH_LEN : swld_pkg::PH_HUNT;
         swld_pkg::PH_LEN: begin
            prd_len   = b;
            prd_phase = swld_pkg::PH_DATA;
         end
         swld_pkg::PH_DATA: begin
            deframe_byte = 1'b1;
            // last byte of the payload is swallowed and closes the frame
            if ({1'b0, prd_cnt} + 9'd1 < {1'b0, prd_len}) begin
               r.data  = b;
               r.index = prd_cnt;
               prd_cnt = prd_cnt + 8'd1;
            end else begin
               r.is_end  = 1'b1;
               r.count   = prd_cnt;
               prd_cnt   = 8'd0;
               prd_phase = swld_pkg::PH_HUNT;
            end
         end
         default: prd_phase = swld_pkg::PH_HUNT;
      endcase
   endfunction

   // Monitor: check results, track csr writes, predict on each byte transfer
   always @(posedge clock) begin
      swld_pkg::result_type want;
      swld_pkg::result_type pred;
      logic                 due;
      if (reset) begin
         prd_phase = swld_pkg::PH_HUNT;
         prd_len   = 8'd0;
         prd_cnt   = 8'd0;
         prd_sync  = {swld_pkg::SyncFourthReset, swld_pkg::SyncThirdReset,
                      swld_pkg::SyncSecondReset, swld_pkg::SyncFirstReset};
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_is_end) frame_ends++;
            if (pending_results.size() == 0) begin
               $error("unexpected result: is_end %0d data %0h index %0d count %0d",
                      rsp_is_end, rsp_data, rsp_index, rsp_count);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_is_end !== want.is_end) begin
                  $error("is_end: expected %0d, actual %0d", want.is_end, rsp_is_end);
                  mismatches++;
               end
               if (rsp_data !== want.data) begin
                  $error("data: expected %0h, actual %0h", want.data, rsp_data);
                  mismatches++;
               end
               if (rsp_index !== want.index) begin
                  $error("index: expected %0d, actual %0d", want.index, rsp_index);
                  mismatches++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_count);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               swld_pkg::CsrSyncFirst:  prd_sync[0] = csr_data;
               swld_pkg::CsrSyncSecond: prd_sync[1] = csr_data;
               swld_pkg::CsrSyncThird:  prd_sync[2] = csr_data;
               swld_pkg::CsrSyncFourth: prd_sync[3] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            sent_bytes++;
            due = deframe_byte(req_rx_byte, pred);
            case (drv_kind)
               CHECK_MODEL: if (due) pending_results.push_back(pred);
               CHECK_GIVEN: pending_results.push_back(drv_want);
               default: ;
            endcase
         end
      end
   end

   // Result backpressure: after each result, hold off the next one a random while
   always @(negedge clock) begin
      if (results_seen != stall_mark) begin
         stall_mark = results_seen;
         if ($urandom_range(0, 19) == 0) rsp_burst = !rsp_burst;
         stall_left = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic int next_gap();
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
      return req_burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Entered and left at a falling edge; valid stays high across gapless bytes
   task automatic send_byte(input logic [7:0] b, input check_type k,
                            input swld_pkg::result_type w, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      drv_kind    <= k;
      drv_want    <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_model(input logic [7:0] b);
      send_byte(b, CHECK_MODEL, NO_RESULT, next_gap());
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Stop sending, drain results, then let bytes without results clear the pipe
   task automatic quiesce(input int extra);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // Random mix: mostly framed traffic, some noise and broken sync words
   task automatic random_traffic(input int budget, input bit long_first);
      int start;
      int len;
      int k;
      int pick;
      bit first;
      start = sent_bytes;
      first = long_first;
      while (sent_bytes - start < budget) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            if (first) len = 255;
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(17, 64);
            else len = $urandom_range(0, 16);
            first = 1'b0;
            for (int i = 0; i < 4; i++) send_model(drv_sync[i]);
            send_model(8'(len));
            for (int i = 0; i < ((len > 1) ? len : 1); i++) send_model(8'($urandom));
         end else if (pick == 7) begin
            repeat ($urandom_range(1, 4)) send_model(8'($urandom));
         end else begin
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++) send_model(drv_sync[i]);
            send_model(drv_sync[k] + 8'($urandom_range(1, 255)));
         end
      end
   endtask

   // Stimulus
   initial begin
      swld_pkg::sync_pattern_type word;
      drv_sync = {swld_pkg::SyncFourthReset, swld_pkg::SyncThirdReset,
                  swld_pkg::SyncSecondReset, swld_pkg::SyncFirstReset};
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(directed[i].rx, directed[i].kind, directed[i].want, next_gap());

      for (int s = 0; s < SETTINGS_COUNT; s++) begin
         if (s > 0) begin
            case (s)
               1: word = '0;
               2: word = '1;
               5: word = {swld_pkg::SyncFourthReset, swld_pkg::SyncThirdReset,
                          swld_pkg::SyncSecondReset, swld_pkg::SyncFirstReset};
               default: word = swld_pkg::sync_pattern_type'($urandom);
            endcase
            quiesce(4);
            csr_write(swld_pkg::CsrSyncFirst,  word[0]);
            csr_write(swld_pkg::CsrSyncSecond, word[1]);
            csr_write(swld_pkg::CsrSyncThird,  word[2]);
            csr_write(swld_pkg::CsrSyncFourth, word[3]);
            // writes past the last register are dropped
            csr_write(csr_index_type'($urandom_range(swld_pkg::CsrSyncFourth + 1,
                                                     (1 << swld_pkg::CsrIndexWidth) - 1)),
                      8'($urandom));
            csr_valid <= 1'b0;
            drv_sync = word;
         end
         random_traffic(ITEMS_PER_SET, s == 2);
      end

      quiesce(DRAIN_CYCLES);
      $display("Sent %0d bytes over %0d sync word settings; checked %0d results, %0d frame ends.",
               sent_bytes, SETTINGS_COUNT, results_seen, frame_ends);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatches, pending_results.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
